[hdl/abs_priority_queue_set_defines.svh]
// Assertion macros for the checker file apqs_checker.sv.
`ifndef ABS_PRIORITY_QUEUE_SET_DEFINES_SVH
`define ABS_PRIORITY_QUEUE_SET_DEFINES_SVH

// Same-cycle implication on the rising edge of i_clk, off during reset.
`define APQS_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("apqs assertion failed");

// Next-cycle implication on the rising edge of i_clk, off during reset.
`define APQS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("apqs assertion failed");

`endif

[hdl/apqs_pkg.sv]
package apqs_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DUP   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // configuration register indexes
    localparam logic CFG_SET_MODE   = 1'b0;
    localparam logic CFG_DUP_SILENT = 1'b1;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_LAST
    } t_idx_op;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_UP,
        WR_DOWN,
        WR_VAL
    } t_wr_op;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_ZERO,
        POS_ABOVE
    } t_pos_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR
    } t_cnt_op;

    typedef struct packed {
        logic    load_in;
        t_idx_op idx_op;
        t_wr_op  wr_op;
        t_pos_op pos_op;
        t_cnt_op cnt_op;
        logic    set_status;
        t_status status;
        logic    set_found;
        logic    cap_popped;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic cnt_zero;
        logic full;
        logic idx_last;
        logic idx_zero;
        logic match;
        logic mag_gt;
        logic set_mode;
        logic dup_silent;
        logic out_free;
    } t_stat;

endpackage

[hdl/apqs_ram.sv]
module apqs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/apqs_ctrl.sv]
module apqs_ctrl
    import apqs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_INS_CHK,
        S_PUT,
        S_POP_HEAD,
        S_SHIFT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    always_comb begin
        n_state        = r_state;
        cmd            = '0;
        cmd.idx_op     = IDX_HOLD;
        cmd.wr_op      = WR_NONE;
        cmd.pos_op     = POS_HOLD;
        cmd.cnt_op     = CNT_HOLD;
        cmd.status     = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    cmd.idx_op  = IDX_ZERO;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_CLEAR: begin
                        cmd.cnt_op = CNT_CLEAR;
                        n_state    = S_FINISH;
                    end
                    OP_POP: begin
                        if (i_stat.cnt_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_EMPTY;
                            n_state        = S_FINISH;
                        end else begin
                            n_state = S_POP_HEAD;
                        end
                    end
                    OP_LOOKUP: begin
                        n_state = i_stat.cnt_zero ? S_FINISH : S_SCAN;
                    end
                    default: begin
                        if (i_stat.set_mode && !i_stat.cnt_zero) begin
                            n_state = S_SCAN;
                        end else if (i_stat.full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                            n_state        = S_FINISH;
                        end else if (i_stat.cnt_zero) begin
                            cmd.pos_op = POS_ZERO;
                            n_state    = S_PUT;
                        end else begin
                            cmd.idx_op = IDX_LAST;
                            n_state    = S_INS_CHK;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    if (i_stat.op == OP_LOOKUP) begin
                        cmd.set_found = 1'b1;
                    end else begin
                        cmd.set_status = 1'b1;
                        cmd.status     = i_stat.dup_silent ? ST_OK : ST_DUP;
                    end
                    n_state = S_FINISH;
                end else if (i_stat.idx_last) begin
                    if (i_stat.op == OP_LOOKUP) begin
                        n_state = S_FINISH;
                    end else if (i_stat.full) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_FULL;
                        n_state        = S_FINISH;
                    end else begin
                        cmd.idx_op = IDX_LAST;
                        n_state    = S_INS_CHK;
                    end
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_INS_CHK: begin
                // walk down from the tail, moving larger magnitudes up one slot
                if (i_stat.mag_gt) begin
                    cmd.wr_op = WR_UP;
                    if (i_stat.idx_zero) begin
                        cmd.pos_op = POS_ZERO;
                        n_state    = S_PUT;
                    end else begin
                        cmd.idx_op = IDX_DEC;
                    end
                end else begin
                    cmd.pos_op = POS_ABOVE;
                    n_state    = S_PUT;
                end
            end
            S_PUT: begin
                cmd.wr_op  = WR_VAL;
                cmd.cnt_op = CNT_INC;
                n_state    = S_FINISH;
            end
            S_POP_HEAD: begin
                cmd.cap_popped = 1'b1;
                if (i_stat.idx_last) begin
                    cmd.cnt_op = CNT_DEC;
                    n_state    = S_FINISH;
                end else begin
                    cmd.idx_op = IDX_INC;
                    n_state    = S_SHIFT;
                end
            end
            S_SHIFT: begin
                cmd.wr_op = WR_DOWN;
                if (i_stat.idx_last) begin
                    cmd.cnt_op = CNT_DEC;
                    n_state    = S_FINISH;
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_FINISH: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = r_in_stall;

endmodule

[hdl/apqs_dp.sv]
module apqs_dp
    import apqs_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    output t_stat                          o_stat,
    input  logic [1:0]                     i_operation,
    input  logic [VALUE_WIDTH-1:0]         i_value,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_index,
    input  logic                           i_cfg_data,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [1:0]                     o_status,
    output logic [VALUE_WIDTH-1:0]         o_popped_value,
    output logic                           o_found,
    output logic [$clog2(DEPTH+1)-1:0]     o_occupancy
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                   r_set_mode;
    logic                   r_dup_silent;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [IW-1:0]          r_idx;
    logic [IW-1:0]          n_idx;
    logic [IW-1:0]          r_pos;
    t_op                    r_op;
    logic [VALUE_WIDTH-1:0] r_val;
    t_status                r_status;
    logic                   r_found;
    logic [VALUE_WIDTH-1:0] r_popped;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [VALUE_WIDTH-1:0] r_out_popped;
    logic                   r_out_found;
    logic [CW-1:0]          r_out_count;

    logic                   we;
    logic [IW-1:0]          waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [VALUE_WIDTH-1:0] rdata;
    logic                   out_free;

    function automatic logic [VALUE_WIDTH-1:0] f_mag(input logic [VALUE_WIDTH-1:0] v);
        f_mag = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    // read address follows the next index, so rdata always shows entry r_idx
    always_comb begin
        case (i_cmd.idx_op)
            IDX_ZERO: n_idx = '0;
            IDX_INC:  n_idx = r_idx + 1'b1;
            IDX_DEC:  n_idx = r_idx - 1'b1;
            IDX_LAST: n_idx = IW'(r_count - 1'b1);
            default:  n_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC:   n_count = r_count + 1'b1;
            CNT_DEC:   n_count = r_count - 1'b1;
            CNT_CLEAR: n_count = '0;
            default:   n_count = r_count;
        endcase
    end

    always_comb begin
        we    = 1'b1;
        wdata = rdata;
        case (i_cmd.wr_op)
            WR_UP:   waddr = r_idx + 1'b1;
            WR_DOWN: waddr = r_idx - 1'b1;
            WR_VAL: begin
                waddr = r_pos;
                wdata = r_val;
            end
            default: begin
                we    = 1'b0;
                waddr = r_idx;
            end
        endcase
    end

    apqs_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(n_idx),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_mode   <= 1'b0;
            r_dup_silent <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SET_MODE:   r_set_mode   <= i_cfg_data;
                    CFG_DUP_SILENT: r_dup_silent <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_count <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        case (i_cmd.pos_op)
            POS_ZERO:  r_pos <= '0;
            POS_ABOVE: r_pos <= r_idx + 1'b1;
            default: begin
            end
        endcase
        if (i_cmd.load_in) begin
            r_op     <= t_op'(i_operation);
            r_val    <= i_value;
            r_status <= ST_OK;
            r_found  <= 1'b0;
            r_popped <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.set_found) begin
            r_found <= 1'b1;
        end
        if (i_cmd.cap_popped) begin
            r_popped <= rdata;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_popped <= r_popped;
            r_out_found  <= r_found;
            r_out_count  <= r_count;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_stat.op         = r_op;
    assign o_stat.cnt_zero   = (r_count == '0);
    assign o_stat.full       = (r_count == CW'(DEPTH));
    assign o_stat.idx_last   = ((CW'(r_idx) + 1'b1) == r_count);
    assign o_stat.idx_zero   = (r_idx == '0);
    assign o_stat.match      = (rdata == r_val);
    assign o_stat.mag_gt     = (f_mag(rdata) > f_mag(r_val));
    assign o_stat.set_mode   = r_set_mode;
    assign o_stat.dup_silent = r_dup_silent;
    assign o_stat.out_free   = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_popped_value = r_out_popped;
    assign o_found        = r_out_found;
    assign o_occupancy    = r_out_count;

endmodule

[hdl/abs_priority_queue_set.sv]
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_operation, i_value
// result    out        o_out_valid / i_out_stall o_status, o_popped_value, o_found,
//                                                o_occupancy
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One request at a time; entries live in a single-port-write RAM walked one slot a cycle.
// In set mode an insert first scans the stored entries for a duplicate; an insert then makes
// a shift pass from the tail down to the slot, and a pop shifts the entries behind the head down.
// Reset empties the store by clearing the count only; no RAM sweep.
// A result waits in the output register under i_out_stall while the next request is taken.
module abs_priority_queue_set
    import apqs_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_operation,
    input  logic signed [VALUE_WIDTH-1:0]   i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic signed [VALUE_WIDTH-1:0]   o_popped_value,
    output logic                            o_found,
    output logic [$clog2(DEPTH+1)-1:0]      o_occupancy,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic                            i_cfg_data
);

    t_cmd                   cmd;
    t_stat                  stat;
    logic [VALUE_WIDTH-1:0] popped;

    apqs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    apqs_dp #(
        .DEPTH      (DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_popped_value(popped),
        .o_found       (o_found),
        .o_occupancy   (o_occupancy)
    );

    assign o_popped_value = popped;
    assign o_cfg_ready    = 1'b1;

endmodule

[hdl/apqs_checker.sv]
`include "abs_priority_queue_set_defines.svh"

module apqs_checker
    import apqs_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [1:0]                    o_status,
    input logic [VALUE_WIDTH-1:0]        o_popped_value,
    input logic                          o_found,
    input logic [$clog2(DEPTH+1)-1:0]    o_occupancy
);

    // a stalled result holds
    `APQS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_popped_value) && $stable(o_found) && $stable(o_occupancy))

    // a rejected insert on a full store leaves it full
    `APQS_ASSERT_IMPL(a_full_occ, o_out_valid && (o_status == ST_FULL), o_occupancy == DEPTH)

    // pop on empty reports an empty store and no value
    `APQS_ASSERT_IMPL(a_empty_pop, o_out_valid && (o_status == ST_EMPTY), (o_occupancy == 0) && (o_popped_value == 0) && !o_found)

    // a hit only comes from lookup, which never pops
    `APQS_ASSERT_IMPL(a_found_ok, o_out_valid && o_found, (o_status == ST_OK) && (o_popped_value == 0) && (o_occupancy != 0))

endmodule

bind abs_priority_queue_set apqs_checker #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
) u_apqs_checker (.*);

[tb/tb_pq_pkg.sv]
`timescale 1ns / 1ps

package tb_pq_pkg;
    import apqs_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int VALUE_W     = 16;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] popped;
        logic               found;
        logic [OCC_W-1:0]   occupancy;
    } t_pq_result;

    class pq_checker;
        logic [VALUE_W-1:0] shadow_entries[$];
        logic               set_mode;
        logic               dup_silent;
        t_pq_result         pending_results[$];
        int                 error_count;
        int                 op_counts[4];
        int                 status_counts[4];

        function new();
            set_mode    = 1'b0;
            dup_silent  = 1'b0;
            error_count = 0;
            foreach (op_counts[i]) op_counts[i] = 0;
            foreach (status_counts[i]) status_counts[i] = 0;
        endfunction

        function logic [VALUE_W-1:0] magnitude_of(logic [VALUE_W-1:0] v);
            // -32768 wraps to itself and reads as 32768 unsigned
            return v[VALUE_W-1] ? (~v + 1'b1) : v;
        endfunction

        function logic holds_value(logic [VALUE_W-1:0] v);
            foreach (shadow_entries[i]) begin
                if (shadow_entries[i] == v) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void write_reg(logic idx, logic data);
            if (idx == CFG_SET_MODE) begin
                set_mode = data;
            end else begin
                dup_silent = data;
            end
        endfunction

        function void note_request(t_op op, logic [VALUE_W-1:0] v);
            t_pq_result r;
            int         pos;
            r = '{status: ST_OK, popped: '0, found: 1'b0, occupancy: '0};
            case (op)
                OP_INSERT: begin
                    if (set_mode && holds_value(v)) begin
                        r.status = dup_silent ? ST_OK : ST_DUP;
                    end else if (shadow_entries.size() >= QUEUE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        // land behind every entry of equal or smaller magnitude
                        pos = 0;
                        while (pos < shadow_entries.size() &&
                               magnitude_of(shadow_entries[pos]) <= magnitude_of(v))
                            pos++;
                        shadow_entries.insert(pos, v);
                    end
                end
                OP_POP: begin
                    if (shadow_entries.size() == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped = shadow_entries.pop_front();
                    end
                end
                OP_LOOKUP: begin
                    r.found = holds_value(v);
                end
                default: begin
                    shadow_entries.delete();
                end
            endcase
            r.occupancy = OCC_W'(shadow_entries.size());
            op_counts[int'(op)]++;
            status_counts[int'(r.status)]++;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(logic [1:0] status, logic signed [VALUE_W-1:0] popped,
                                   logic found, logic [OCC_W-1:0] occupancy);
            t_pq_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request outstanding: status %0d, occupancy %0d",
                         $time, status, occupancy);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, status);
            compare_field("popped_value", $signed(want.popped), popped);
            compare_field("found", want.found, found);
            compare_field("occupancy", want.occupancy, occupancy);
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import apqs_pkg::*;
    import tb_pq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 185;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [1:0]                i_operation = OP_INSERT;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [1:0]                o_status;
    logic signed [VALUE_W-1:0] o_popped_value;
    logic                      o_found;
    logic [OCC_W-1:0]          o_occupancy;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic                      i_cfg_index = CFG_SET_MODE;
    logic                      i_cfg_data = 1'b0;

    pq_checker chk;
    int        quiet_cycles = 0;
    int        stall_run = 0;
    int        stall_pct = 0;

    abs_priority_queue_set #(
        .DEPTH       (QUEUE_DEPTH),
        .VALUE_WIDTH (VALUE_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_found        (o_found),
        .o_occupancy    (o_occupancy),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // receiver: runs of random length, each with its own stall density
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_run <= $urandom_range(4, 40);
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 25;
                2: stall_pct <= 60;
                default: stall_pct <= 95;
            endcase
        end else begin
            stall_run <= stall_run - 1;
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) chk.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) chk.note_request(t_op'(i_operation), i_value);
            if (o_out_valid && !i_out_stall) begin
                chk.check_result(o_status, o_popped_value, o_found, o_occupancy);
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // leaves i_in_valid high; the caller drops it when a gap follows
    task automatic send_request(t_op op, logic [VALUE_W-1:0] v);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= v;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_cfg(logic set_mode_val, logic dup_silent_val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SET_MODE;
        i_cfg_data  <= set_mode_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_DUP_SILENT;
        i_cfg_data  <= dup_silent_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (chk.pending_results.size() != 0);
    endtask

    task automatic pick_request(int fill_bias, output t_op op, output logic [VALUE_W-1:0] v);
        int roll;
        int ins_pct;
        int n;
        ins_pct = (fill_bias == 2) ? 75 : (fill_bias == 1) ? 45 : 20;
        roll    = $urandom_range(0, 99);
        if (roll < 1) begin
            op = OP_CLEAR;
        end else if (roll < 1 + ins_pct) begin
            op = OP_INSERT;
        end else if (roll < 1 + ins_pct + (99 - ins_pct) / 2) begin
            op = OP_POP;
        end else begin
            op = OP_LOOKUP;
        end
        roll = $urandom_range(0, 9);
        n    = chk.shadow_entries.size();
        if (roll < 4) begin
            // narrow pool: duplicates and equal magnitudes of both signs
            v = VALUE_W'($urandom_range(0, 16)) - VALUE_W'(8);
        end else if (roll < 6 && n > 0) begin
            v = chk.shadow_entries[$urandom_range(0, n - 1)];
        end else if (roll < 8) begin
            case ($urandom_range(0, 5))
                0: v = 16'h7FFF;
                1: v = 16'h8001;
                2: v = 16'h8000;
                3: v = 16'h0000;
                4: v = 16'hFFFF;
                default: v = 16'h0001;
            endcase
        end else begin
            v = VALUE_W'($urandom);
        end
    endtask

    task automatic run_phase(logic set_mode_val, logic dup_silent_val, int n_items);
        int          sent;
        int          burst;
        int          gap;
        int          fill_bias;
        logic        drain;
        t_op         op;
        logic [VALUE_W-1:0] v;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_cfg(set_mode_val, dup_silent_val);
        sent = 0;
        while (sent < n_items) begin
            burst     = $urandom_range(1, 24);
            fill_bias = $urandom_range(0, 2);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                pick_request(fill_bias, op, v);
                send_request(op, v);
                sent++;
            end
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            drain = ($urandom_range(0, 15) == 0);
            if (gap > 0 || drain) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                // hold off until the block has answered everything
                if (drain) wait_drained();
            end
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        logic set_modes[5];
        logic dup_modes[5];
        set_modes = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        dup_modes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        chk = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_cfg(1'b0, 1'b0);

        // plain queue: empty cases, extremes, equal magnitudes, fill to full
        send_request(OP_POP, 16'h0000);
        send_request(OP_LOOKUP, 16'h0000);
        send_request(OP_INSERT, 16'h0005);
        send_request(OP_INSERT, 16'hFFFB);
        send_request(OP_INSERT, 16'h7FFF);
        send_request(OP_INSERT, 16'h8001);
        send_request(OP_INSERT, 16'h8000);
        send_request(OP_INSERT, 16'h0000);
        send_request(OP_INSERT, 16'h0001);
        send_request(OP_INSERT, 16'hFFFF);
        send_request(OP_INSERT, 16'h0005);
        send_request(OP_INSERT, 16'h0064);
        send_request(OP_INSERT, 16'hFF38);
        send_request(OP_INSERT, 16'h012C);
        send_request(OP_INSERT, 16'hFE70);
        send_request(OP_INSERT, 16'h1234);
        send_request(OP_INSERT, 16'h0002);
        send_request(OP_INSERT, 16'hFFFD);
        send_request(OP_INSERT, 16'h0007);
        send_request(OP_LOOKUP, 16'h8000);
        send_request(OP_LOOKUP, 16'h7FFF);
        send_request(OP_LOOKUP, 16'h3039);
        send_request(OP_POP, 16'hAAAA);
        send_request(OP_POP, 16'h5555);
        send_request(OP_CLEAR, 16'hFFFF);
        i_in_valid <= 1'b0;

        for (int p = 0; p < 5; p++) run_phase(set_modes[p], dup_modes[p], PHASE_ITEMS);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests (%0d inserts, %0d pops, %0d lookups, %0d clears)",
                 chk.op_counts[OP_INSERT] + chk.op_counts[OP_POP] +
                 chk.op_counts[OP_LOOKUP] + chk.op_counts[OP_CLEAR],
                 chk.op_counts[OP_INSERT], chk.op_counts[OP_POP],
                 chk.op_counts[OP_LOOKUP], chk.op_counts[OP_CLEAR]);
        $display("over all four mode settings: %0d ok, %0d empty pops, %0d duplicates, %0d full",
                 chk.status_counts[ST_OK], chk.status_counts[ST_EMPTY],
                 chk.status_counts[ST_DUP], chk.status_counts[ST_FULL]);
        if (chk.error_count == 0 && chk.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
